// File: rtl/urlpd_pkg.sv
`default_nettype none

package urlpd_pkg;

  localparam int LIMIT_W         = 16;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int SLOTS           = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  // Register indexes on the configuration port.
  localparam logic REG_OUTPUT_LIMIT = 1'b0;

  localparam logic [7:0] CHR_PCT   = 8'h25;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  // One classified input item: up to three candidate bytes in emit order.
  typedef struct packed {
    logic [1:0]            n;
    logic [SLOTS-1:0][7:0] bytes;
    logic                  last;
  } urlpd_entry_t;

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
             (b >= 8'h61 && b <= 8'h66);
  endfunction

  // Letters of either case share the low nibble; 'A' and 'a' map to ten.
  function automatic logic [3:0] hex_val(input logic [7:0] b);
    if (b <= 8'h39) begin
      hex_val = b[3:0];
    end else begin
      hex_val = b[3:0] + 4'd9;
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/urlpd_front.sv
`default_nettype none

module urlpd_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic [7:0]            in_byte,
  input  wire logic                  in_last,
  output      logic                  push,
  output      urlpd_pkg::urlpd_entry_t push_entry
);
  import urlpd_pkg::*;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_PCT  = 2'd1;
  localparam logic [1:0] P_DIG  = 2'd2;

  logic [1:0] pend_r, pend_nxt;
  logic [7:0] held_r, held_nxt;
  logic       accept;
  logic       hex;
  logic       do_idle;
  logic [1:0] n;
  logic [SLOTS-1:0][7:0] bts;

  assign accept = in_valid && !in_stall;
  assign hex    = is_hex(in_byte);

  always_comb begin
    n        = 2'd0;
    bts      = '0;
    pend_nxt = pend_r;
    held_nxt = held_r;
    do_idle  = 1'b0;

    case (pend_r)
      P_IDLE: begin
        do_idle = 1'b1;
      end
      P_PCT: begin
        if (hex) begin
          held_nxt = in_byte;
          pend_nxt = P_DIG;
        end else begin
          pend_nxt = P_IDLE;
          bts[n] = CHR_PCT; n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      P_DIG: begin
        pend_nxt = P_IDLE;
        if (hex) begin
          bts[n] = {hex_val(held_r), hex_val(in_byte)}; n = n + 2'd1;
        end else begin
          bts[n] = CHR_PCT; n = n + 2'd1;
          bts[n] = held_r;  n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      default: begin
        pend_nxt = P_IDLE;
      end
    endcase

    if (do_idle) begin
      if (in_byte == CHR_PCT) begin
        pend_nxt = P_PCT;
      end else if (in_byte == CHR_PLUS) begin
        bts[n] = CHR_SPACE; n = n + 2'd1;
      end else begin
        bts[n] = in_byte; n = n + 2'd1;
      end
    end

    // An escape left open at the end of the string is flushed literally.
    if (in_last) begin
      if (pend_nxt == P_PCT && n != 2'd3) begin
        bts[n] = CHR_PCT; n = n + 2'd1;
      end else if (pend_nxt == P_DIG && n == 2'd0) begin
        bts[0] = CHR_PCT;
        bts[1] = held_nxt;
        n = 2'd2;
      end
      pend_nxt = P_IDLE;
      held_nxt = 8'h00;
    end
  end

  assign push             = accept && (n != 2'd0 || in_last);
  assign push_entry.n     = n;
  assign push_entry.bytes = bts;
  assign push_entry.last  = in_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= P_IDLE;
      held_r <= 8'h00;
    end else if (accept) begin
      pend_r <= pend_nxt;
      held_r <= held_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> pend_r == P_IDLE)
    else $error("escape state survived the end of a string");

  assert property (@(posedge clk) disable iff (!rst_n)
    push && push_entry.last |-> push_entry.n != 2'd0)
    else $error("last item of a string classified with no bytes");

endmodule

`default_nettype wire

// File: rtl/urlpd_queue.sv
`default_nettype none

module urlpd_queue #(
  parameter int DEPTH = urlpd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire urlpd_pkg::urlpd_entry_t push_entry,
  input  wire logic                    pop,
  output      logic                    full,
  output      logic                    head_valid,
  output      urlpd_pkg::urlpd_entry_t head
);
  import urlpd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  urlpd_entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      wrap_inc = '0;
    end else begin
      wrap_inc = p + PW'(1);
    end
  endfunction

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && !head_valid))
    else $error("queue overrun or underrun");

endmodule

`default_nettype wire

// File: rtl/urlpd_back.sv
`default_nettype none

module urlpd_back #(
  parameter int COUNT_BITS = urlpd_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [urlpd_pkg::LIMIT_W-1:0] output_limit,
  input  wire logic                          head_valid,
  input  wire urlpd_pkg::urlpd_entry_t       head,
  output      logic                          pop,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [7:0]                    out_byte,
  output      logic                          out_last,
  output      logic                          out_overflow
);
  import urlpd_pkg::*;

  localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  logic [1:0]            idx_r, idx_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  failed_r, failed_nxt;
  logic                  out_valid_r;
  logic [7:0]            out_byte_r;
  logic                  out_last_r;
  logic                  out_ovf_r;

  logic       go;
  logic       load;
  logic       room;
  logic       final_slot;
  logic [7:0] slot_byte;
  logic [7:0] ob;
  logic       ol;
  logic       oo;

  assign go   = head_valid && (!out_valid_r || !out_stall);
  assign room = (CMP_W'(count_r) < CMP_W'(output_limit)) && (count_r != '1);
  assign final_slot = (idx_r == head.n - 2'd1);

  always_comb begin
    case (idx_r)
      2'd0:    slot_byte = head.bytes[0];
      2'd1:    slot_byte = head.bytes[1];
      2'd2:    slot_byte = head.bytes[2];
      default: slot_byte = 8'h00;
    endcase
  end

  always_comb begin
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    failed_nxt = failed_r;
    pop        = 1'b0;
    load       = 1'b0;
    ob         = 8'h00;
    ol         = 1'b0;
    oo         = 1'b0;

    if (go) begin
      if (failed_r || idx_r >= head.n) begin
        // Failed or empty items drop; a last one sends 0, overflow if failed.
        pop     = 1'b1;
        idx_nxt = 2'd0;
        if (head.last) begin
          load       = 1'b1;
          ol         = 1'b1;
          oo         = failed_r;
          count_nxt  = '0;
          failed_nxt = 1'b0;
        end
      end else if (room) begin
        load      = 1'b1;
        ob        = slot_byte;
        ol        = head.last && final_slot;
        count_nxt = count_r + COUNT_BITS'(1);
        if (final_slot) begin
          pop     = 1'b1;
          idx_nxt = 2'd0;
          if (head.last) begin
            count_nxt = '0;
          end
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end else begin
        failed_nxt = 1'b1;
        if (!head.last) begin
          pop     = 1'b1;
          idx_nxt = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      count_r     <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      count_r  <= count_nxt;
      failed_r <= failed_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= ob;
      out_last_r <= ol;
      out_ovf_r  <= oo;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ovf_r |-> out_last_r && out_byte_r == 8'h00)
    else $error("overflow reported outside a final zero item");

  assert property (@(posedge clk) disable iff (!rst_n)
    load && ol |=> count_r == '0 && !failed_r && idx_r == 2'd0)
    else $error("string state not cleared after its final item");

endmodule

`default_nettype wire

// File: rtl/url_percent_decoder.sv
`default_nettype none

// URL percent decoder with plus-as-space.
// Input channel: one encoded byte per item (in_byte, in_last marks the end of
// a string), accepted on in_valid high and in_stall low. Result channel: one
// decoded byte per item (out_byte, out_last, out_overflow), taken on out_valid
// high and out_stall low. The output_limit register sits at byte address 0 of
// the APB port and must only be written while the block is idle.
// A front stage classifies each input byte into up to three candidate bytes
// and queues them; a back stage counts them against the limit and presents
// them one per cycle while out_stall is low, from an output register. A result
// passes through the queue and the output register before it shows on out_valid.
// Throughput is one input item per cycle while out_stall is low and each item
// yields at most one byte; a broken escape, or an escape left open at the end
// of a string, yields two or three bytes and holds the back stage while they
// go out, and a limit failure on the final item of a string holds it again
// for the overflow item. The queue of QUEUE_DEPTH entries absorbs these, and
// in_stall rises when it is full. While out_stall is high the output register
// holds its item and the queue fills. Reset sets output_limit to 65535 and
// clears the escape state, byte count, failure flag, queue and out_valid.
module url_percent_decoder #(
  parameter int COUNT_BITS  = urlpd_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = urlpd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [7:0]  out_byte,
  output      logic        out_last,
  output      logic        out_overflow,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  import urlpd_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic               cfg_wr;
  logic               push;
  logic               pop;
  logic               full;
  logic               head_valid;
  urlpd_entry_t       push_entry;
  urlpd_entry_t       head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr && paddr[2] == REG_OUTPUT_LIMIT) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_OUTPUT_LIMIT) ? {{(32-LIMIT_W){1'b0}}, limit_r} : 32'h0;

  assign in_stall = full;

  urlpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .push       (push),
    .push_entry (push_entry)
  );

  urlpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  urlpd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .output_limit (limit_r),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

endmodule

`default_nettype wire

// File: dv/url_percent_decoder_tb.sv
`default_nettype none

module url_percent_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import urlpd_pkg::*;

  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_UPPER = 8'h41;
  localparam logic [7:0] CHR_LOWER = 8'h61;
  localparam logic [2:0] LIMIT_ADDR = {REG_OUTPUT_LIMIT, 2'b00};
  localparam int         COUNT_CAP = (1 << COUNT_BITS_DEF) - 1;
  localparam int         LONG_HOLD_CYCLES = 120;

  typedef enum logic [1:0] {
    ESC_IDLE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } dec_out_t;

  // Decoder model plus the list of decoded bytes still owed by the block.
  class decode_scoreboard;
    dec_out_t   owed_q[$];
    dec_out_t   item_res[SLOTS];
    int         n_item;
    logic [15:0] limit;
    esc_state_t esc;
    logic [7:0] first_digit;
    int         written;
    bit         failed;
    int         errors;
    int         n_checked;

    function new();
      limit = LIMIT_RESET;
      esc = ESC_IDLE;
      first_digit = 8'h00;
      written = 0;
      failed = 1'b0;
      errors = 0;
      n_checked = 0;
    endfunction

    static function bit hex_digit(logic [7:0] b);
      return (b >= CHR_ZERO && b <= CHR_NINE) ||
             (b >= CHR_UPPER && b < CHR_UPPER + 8'd6) ||
             (b >= CHR_LOWER && b < CHR_LOWER + 8'd6);
    endfunction

    static function logic [3:0] nibble(logic [7:0] b);
      logic [7:0] v;
      if (b <= CHR_NINE) begin
        v = b - CHR_ZERO;
      end else if (b >= CHR_LOWER) begin
        v = b - CHR_LOWER + 8'd10;
      end else begin
        v = b - CHR_UPPER + 8'd10;
      end
      return v[3:0];
    endfunction

    function void set_limit(logic [15:0] v);
      limit = v;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) begin
        $display("mismatch: %s", msg);
      end
    endfunction

    function void add(logic [7:0] b, logic l, logic o);
      if (n_item < SLOTS) begin
        item_res[n_item] = '{data: b, last: l, ovf: o};
        n_item++;
      end
    endfunction

    // A byte goes out only while the string is under its limit.
    function void emit_byte(logic [7:0] b);
      if (failed) begin
        return;
      end
      if (written >= int'(limit) || written >= COUNT_CAP) begin
        failed = 1'b1;
        return;
      end
      add(b, 1'b0, 1'b0);
      written++;
    endfunction

    function void plain_byte(logic [7:0] b);
      if (b == CHR_PCT) begin
        esc = ESC_PCT;
      end else if (b == CHR_PLUS) begin
        emit_byte(CHR_SPACE);
      end else begin
        emit_byte(b);
      end
    endfunction

    function void note_input(logic [7:0] b, logic l);
      n_item = 0;
      if (!failed) begin
        case (esc)
          ESC_IDLE: begin
            plain_byte(b);
          end
          ESC_PCT: begin
            if (hex_digit(b)) begin
              first_digit = b;
              esc = ESC_DIGIT;
            end else begin
              esc = ESC_IDLE;
              emit_byte(CHR_PCT);
              plain_byte(b);
            end
          end
          default: begin
            esc = ESC_IDLE;
            if (hex_digit(b)) begin
              emit_byte({nibble(first_digit), nibble(b)});
            end else begin
              emit_byte(CHR_PCT);
              emit_byte(first_digit);
              plain_byte(b);
            end
          end
        endcase
      end
      if (l) begin
        // An unfinished escape is flushed literally at the end of the string.
        if (!failed && esc == ESC_PCT) begin
          emit_byte(CHR_PCT);
        end else if (!failed && esc == ESC_DIGIT) begin
          emit_byte(CHR_PCT);
          emit_byte(first_digit);
        end
        if (failed) begin
          add(8'h00, 1'b1, 1'b1);
        end else if (n_item == 0) begin
          add(8'h00, 1'b1, 1'b0);
        end else begin
          item_res[n_item-1].last = 1'b1;
        end
        esc = ESC_IDLE;
        first_digit = 8'h00;
        written = 0;
        failed = 1'b0;
      end
      for (int i = 0; i < n_item; i++) begin
        owed_q.push_back(item_res[i]);
      end
    endfunction

    function void check_result(logic [7:0] b, logic l, logic o);
      dec_out_t e;
      n_checked++;
      if (owed_q.size() == 0) begin
        fail($sformatf("result %0d with none expected: byte %h last %b overflow %b",
                       n_checked, b, l, o));
        return;
      end
      e = owed_q.pop_front();
      if (b !== e.data || l !== e.last || o !== e.ovf) begin
        fail($sformatf("result %0d: byte %h/%h last %b/%b overflow %b/%b (exp/act)",
                       n_checked, e.data, b, e.last, l, e.ovf, o));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_overflow;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  logic        idle_on = 1'b1;
  logic        rx_hold = 1'b0;
  int          rx_burst = 0;
  int          items_sent = 0;
  bit          pause_pending = 1'b0;
  logic [7:0]  str_q[$];
  decode_scoreboard sb;

  url_percent_decoder u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .out_overflow(out_overflow),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stall bursts, overridden by the long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_burst <= 0;
    end else if (rx_hold) begin
      out_stall <= 1'b1;
    end else if (rx_burst != 0) begin
      out_stall <= 1'b1;
      rx_burst <= rx_burst - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      rx_burst <= $urandom_range(0, 17);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_byte, out_last, out_overflow);
    end
  end

  // Long receiver hold while the sender keeps offering items, to fill the queue.
  initial begin
    wait (items_sent >= 50);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_item(input logic [7:0] b, input logic l);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(b, l);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_str_q();
    for (int i = 0; i < str_q.size(); i++) begin
      // One pause mid-string until the block has delivered everything owed.
      if (pause_pending && i == 1) begin
        pause_pending = 1'b0;
        drain_results();
      end
      send_item(str_q[i], i == str_q.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    str_q.delete();
    for (int i = 0; i < s.len(); i++) begin
      str_q.push_back(s[i]);
    end
    send_str_q();
  endtask

  task automatic write_limit(input logic [15:0] v);
    logic [31:0] rd;
    drain_results();
    repeat (8) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= {16'h0000, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_limit(v);
    if (rd[15:0] !== v) begin
      sb.fail($sformatf("output_limit read back %h, wrote %h", rd[15:0], v));
    end
  endtask

  function automatic logic [7:0] rand_hex();
    case ($urandom_range(0, 2))
      0:       return CHR_ZERO + 8'($urandom_range(0, 9));
      1:       return CHR_UPPER + 8'($urandom_range(0, 5));
      default: return CHR_LOWER + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] rand_nonhex();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (decode_scoreboard::hex_digit(b));
    return b;
  endfunction

  // Mostly well-formed escapes and plain bytes, with broken escapes as noise.
  task automatic add_token();
    case ($urandom_range(0, 9))
      0, 1, 2: str_q.push_back(8'($urandom_range(0, 255)));
      3:       str_q.push_back(CHR_PLUS);
      4, 5, 6: begin
        str_q.push_back(CHR_PCT);
        str_q.push_back(rand_hex());
        str_q.push_back(rand_hex());
      end
      7: begin
        str_q.push_back(CHR_PCT);
        str_q.push_back(rand_nonhex());
      end
      8: begin
        str_q.push_back(CHR_PCT);
        str_q.push_back(rand_hex());
        str_q.push_back(rand_nonhex());
      end
      default: str_q.push_back(CHR_PCT);
    endcase
  endtask

  task automatic random_phase(input int n);
    int stop_at;
    int n_tok;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      str_q.delete();
      n_tok = $urandom_range(1, 6);
      for (int t = 0; t < n_tok; t++) begin
        add_token();
      end
      send_str_q();
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings at the reset limit.
    send_text("%41");
    send_text("%6a");
    send_text("%FF");
    send_text("+");
    send_text("%G");
    send_text("%4x");
    send_text("%");
    send_text("%4");
    send_text("%%41");
    str_q = '{8'h00};
    send_str_q();
    str_q = '{8'hFF};
    send_str_q();

    // Limit at and near zero.
    write_limit(16'd0);
    send_text("a");
    write_limit(16'd1);
    send_text("ab");
    write_limit(16'd2);
    send_text("%4x");

    write_limit(16'hFFFF);
    pause_pending = 1'b1;
    random_phase(60);

    write_limit(16'd3);
    random_phase(40);

    write_limit(16'd0);
    random_phase(15);

    write_limit(16'($urandom_range(4, 12)));
    random_phase(40);

    write_limit(16'hFFFF);
    idle_on <= 1'b0;
    random_phase(50);

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/urlpd_pkg.sv
rtl/urlpd_front.sv
rtl/urlpd_queue.sv
rtl/urlpd_back.sv
rtl/url_percent_decoder.sv
dv/url_percent_decoder_tb.sv
